// File: rtl/core/png_color_chunk_stripper_unit_macros.svh
// assertion macros shared by the png chunk stripper rtl
`ifndef PNG_COLOR_CHUNK_STRIPPER_UNIT_MACROS_SVH
`define PNG_COLOR_CHUNK_STRIPPER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define PNGCS_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// property checked on every clock edge, reset included
`define PNGCS_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define PNGCS_ASSERT(label, clk_s, rst_s, prop, msg)
`define PNGCS_ASSERT_ALWAYS(label, clk_s, prop, msg)
`endif

`endif

// File: rtl/core/pngcs_pkg.sv
// types, constants and helpers for the png chunk stripper
package pngcs_pkg;

  // parser phases
  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_BODY = 3'd2;
  localparam logic [2:0] PH_TAIL = 3'd3;
  localparam logic [2:0] PH_ERR  = 3'd4;

  // closing status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIG   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_AFTER_END = 3'd3;
  localparam logic [2:0] ST_NO_END    = 3'd4;

  // chunk type codes
  localparam logic [31:0] TYPE_GAMA = 32'h67414D41;
  localparam logic [31:0] TYPE_CHRM = 32'h6348524D;
  localparam logic [31:0] TYPE_SRGB = 32'h73524742;
  localparam logic [31:0] TYPE_ICCP = 32'h69434350;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;

  // drop mask bits
  localparam int MASK_GAMA = 0;
  localparam int MASK_CHRM = 1;
  localparam int MASK_SRGB = 2;
  localparam int MASK_ICCP = 3;
  localparam logic [3:0] DROP_MASK_RESET = 4'hF;

  // chunk framing: header bytes, bytes after the header beyond the payload (crc)
  localparam int HDR_BYTES = 8;
  localparam int HDR_CNT_W = $clog2(HDR_BYTES);
  localparam int CRC_BYTES = 4;
  localparam int COUNT_W   = 33;

  // command queue between parser and output sequencer
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pngcs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] status;
    logic       last_result;
  } pngcs_out_t;

  // one parser step worth of results: a single result or a held chunk header
  typedef struct packed {
    logic        is_hdr;
    logic [63:0] data;
    logic        byte_valid;
    logic        done_res;
    logic [2:0]  status;
  } pngcs_cmd_t;

  // png file signature byte by position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // whether a chunk type is stripped under the given mask
  function automatic logic type_dropped(input logic [31:0] t, input logic [3:0] mask);
    logic d;
    d = 1'b0;
    if (t == TYPE_GAMA) d = mask[MASK_GAMA];
    if (t == TYPE_CHRM) d = mask[MASK_CHRM];
    if (t == TYPE_SRGB) d = mask[MASK_SRGB];
    if (t == TYPE_ICCP) d = mask[MASK_ICCP];
    return d;
  endfunction

endpackage

// File: rtl/core/pngcs_front.sv
// byte parser: signature check, chunk framing, drop decision, closing status
`include "png_color_chunk_stripper_unit_macros.svh"

module pngcs_front import pngcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  pngcs_in_t  data,
  input  logic [3:0] drop_mask,
  output logic       cmd_push,
  output pngcs_cmd_t cmd
);

  logic [2:0]         phase, phase_next;
  logic [COUNT_W-1:0] cnt, cnt_next;
  logic [55:0]        hold, hold_next;
  logic               drop, drop_next;
  logic               is_end, is_end_next;
  logic [2:0]         err, err_next;

  logic [63:0] hdr_word;
  logic [31:0] chunk_type;
  logic [31:0] chunk_len;
  logic        emit;
  logic [2:0]  st;

  assign hdr_word   = {hold, data.data_byte};
  assign chunk_type = hdr_word[31:0];
  assign chunk_len  = hdr_word[63:32];

  // per-transaction parse step
  always_comb begin
    phase_next  = phase;
    cnt_next    = cnt;
    hold_next   = hold;
    drop_next   = drop;
    is_end_next = is_end;
    err_next    = err;
    emit        = 1'b0;
    st          = ST_OK;
    cmd         = '0;
    if (accept) begin
      unique case (phase)
        PH_SIG: begin
          if (data.data_byte == sig_byte(cnt[2:0])) begin
            emit            = 1'b1;
            cmd.data        = {56'd0, data.data_byte};
            cmd.byte_valid  = 1'b1;
            if (cnt[2:0] == 3'(HDR_BYTES - 1)) begin
              phase_next = PH_HDR;
              cnt_next   = '0;
            end else begin
              cnt_next = cnt + COUNT_W'(1);
            end
          end else begin
            err_next   = ST_BAD_SIG;
            phase_next = PH_ERR;
          end
        end
        PH_HDR: begin
          hold_next = hdr_word[55:0];
          cnt_next  = cnt + COUNT_W'(1);
          if (cnt[2:0] == 3'(HDR_BYTES - 1) && !data.last_byte) begin
            is_end_next = (chunk_type == TYPE_IEND);
            drop_next   = type_dropped(chunk_type, drop_mask);
            if (!type_dropped(chunk_type, drop_mask)) begin
              emit           = 1'b1;
              cmd.is_hdr     = 1'b1;
              cmd.data       = hdr_word;
              cmd.byte_valid = 1'b1;
            end
            phase_next = PH_BODY;
            cnt_next   = {1'b0, chunk_len} + COUNT_W'(CRC_BYTES);
          end
        end
        PH_BODY: begin
          if (!drop) begin
            emit           = 1'b1;
            cmd.data       = {56'd0, data.data_byte};
            cmd.byte_valid = 1'b1;
          end
          cnt_next = cnt - COUNT_W'(1);
          if (cnt == COUNT_W'(1)) begin
            phase_next = is_end ? PH_TAIL : PH_HDR;
            hold_next  = '0;
            drop_next  = 1'b0;
          end
        end
        PH_TAIL: begin
          err_next   = ST_AFTER_END;
          phase_next = PH_ERR;
        end
        default: begin
        end
      endcase

      // closing status on the final byte of the file
      if (data.last_byte) begin
        if (err_next != ST_OK) begin
          st = err_next;
        end else if (phase_next == PH_SIG) begin
          st = ST_BAD_SIG;
        end else if (phase_next == PH_TAIL) begin
          st = ST_OK;
        end else if (phase_next == PH_HDR && cnt_next == '0) begin
          st = ST_NO_END;
        end else begin
          st = ST_TRUNC;
        end
        emit         = 1'b1;
        cmd.done_res = 1'b1;
        cmd.status   = st;
        phase_next   = PH_SIG;
        cnt_next     = '0;
        hold_next    = '0;
        drop_next    = 1'b0;
        is_end_next  = 1'b0;
        err_next     = ST_OK;
      end
    end
  end

  assign cmd_push = emit;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SIG;
      cnt    <= '0;
      hold   <= '0;
      drop   <= 1'b0;
      is_end <= 1'b0;
      err    <= ST_OK;
    end else begin
      phase  <= phase_next;
      cnt    <= cnt_next;
      hold   <= hold_next;
      drop   <= drop_next;
      is_end <= is_end_next;
      err    <= err_next;
    end
  end

  `PNGCS_ASSERT(a_err_phase_has_code, clk, rst, (phase == PH_ERR) |-> (err != ST_OK), "error phase without error code")
  `PNGCS_ASSERT(a_sig_count_small, clk, rst, (phase == PH_SIG) |-> (cnt[COUNT_W-1:3] == '0), "signature count out of range")
  `PNGCS_ASSERT(a_last_restarts_file, clk, rst, (accept && data.last_byte) |=> (phase == PH_SIG && err == ST_OK), "file state not cleared after last byte")
  `PNGCS_ASSERT_ALWAYS(a_reset_state, clk, rst |=> (phase == PH_SIG && cnt == '0), "parser not in signature phase after reset")

endmodule

// File: rtl/core/pngcs_fifo.sv
// short command queue between the parser and the output sequencer
module pngcs_fifo import pngcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pngcs_cmd_t wdata,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output pngcs_cmd_t rdata
);

  pngcs_cmd_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/pngcs_back.sv
// output sequencer: turns queued commands into result transactions
`include "png_color_chunk_stripper_unit_macros.svh"

module pngcs_back import pngcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  pngcs_cmd_t q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output pngcs_out_t result
);

  logic                 out_valid;
  logic [HDR_CNT_W-1:0] hdr_cnt;
  logic [55:0]          hdr_shift;
  logic                 advance;
  logic                 in_burst;

  assign advance  = !out_valid || pop;
  assign in_burst = (hdr_cnt != '0);
  assign q_pop    = advance && !in_burst && !q_empty;
  assign empty    = !out_valid;

  // output valid and header burst counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hdr_cnt   <= '0;
    end else if (advance) begin
      if (in_burst) begin
        out_valid <= 1'b1;
        hdr_cnt   <= hdr_cnt - HDR_CNT_W'(1);
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        hdr_cnt   <= q_head.is_hdr ? HDR_CNT_W'(HDR_BYTES - 1) : '0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register and remaining header bytes
  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_burst) begin
        result.out_byte    <= hdr_shift[55:48];
        result.byte_valid  <= 1'b1;
        result.done_res    <= 1'b0;
        result.status      <= ST_OK;
        result.last_result <= (hdr_cnt == HDR_CNT_W'(1));
        hdr_shift          <= {hdr_shift[47:0], 8'd0};
      end else if (!q_empty) begin
        if (q_head.is_hdr) begin
          result.out_byte    <= q_head.data[63:56];
          result.byte_valid  <= 1'b1;
          result.done_res    <= 1'b0;
          result.status      <= ST_OK;
          result.last_result <= 1'b0;
          hdr_shift          <= q_head.data[55:0];
        end else begin
          result.out_byte    <= q_head.data[7:0];
          result.byte_valid  <= q_head.byte_valid;
          result.done_res    <= q_head.done_res;
          result.status      <= q_head.status;
          result.last_result <= 1'b1;
        end
      end
    end
  end

  `PNGCS_ASSERT(a_burst_has_output, clk, rst, in_burst |-> out_valid, "header burst running with no result held")
  `PNGCS_ASSERT(a_done_is_last, clk, rst, (out_valid && result.done_res) |-> result.last_result, "closing result not marked last")
  `PNGCS_ASSERT(a_empty_result_closes, clk, rst, (out_valid && !result.byte_valid) |-> (result.done_res && result.out_byte == 8'd0), "result without byte does not close the file")

endmodule

// File: rtl/core/png_color_chunk_stripper_unit.sv
// top level of the png color chunk stripper
// Streams a PNG file one byte per transaction and passes the signature and every
// kept chunk unchanged, stripping gAMA, cHRM, sRGB and iCCP chunks whose bit is set
// in the drop mask (reset 4'hF, sampled when a chunk header completes). A byte is
// taken every clock while full is low, and results leave at one per clock while pop
// is high. The eight header bytes of a chunk are held in the parser until the last type
// byte arrives and, for a kept chunk, then come out as eight consecutive results; the
// output sequencer drains them while the parser keeps accepting body bytes into a
// four-entry command queue until it fills. Each result is registered in the command
// queue and then in the output result register. The last byte of a file closes it
// with done_res and a status (ok, bad signature, truncated, data after IEND, no IEND)
// on its final result, which is a byte-less result if that byte passes nothing.
module png_color_chunk_stripper_unit import pngcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  pngcs_in_t  data,
  output logic       empty,
  input  logic       pop,
  output pngcs_out_t result,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  logic [3:0] mask;
  logic       accept;
  logic       cmd_push;
  pngcs_cmd_t cmd;
  logic       q_empty;
  logic       q_pop;
  pngcs_cmd_t q_head;

  assign accept = push && !full;

  // drop mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= DROP_MASK_RESET;
    end else if (cfg_we) begin
      mask <= cfg_wdata;
    end
  end

  pngcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data      (data),
    .drop_mask (mask),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  pngcs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd),
    .full  (full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_head)
  );

  pngcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  `include "png_color_chunk_stripper_unit_macros.svh"

  `PNGCS_ASSERT(a_no_push_when_full, clk, rst, full |-> !cmd_push, "command generated while queue full")
  `PNGCS_ASSERT(a_cmd_only_on_accept, clk, rst, cmd_push |-> accept, "command without an accepted byte")
  `PNGCS_ASSERT(a_mask_write, clk, rst, cfg_we |=> (mask == $past(cfg_wdata)), "drop mask write lost")

endmodule

// File: test/png_color_chunk_stripper_unit_test.sv
// self-checking testbench for the png color chunk stripper
module png_color_chunk_stripper_unit_test import pngcs_pkg::*;;

  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BYTES_PER_PHASE = 8;
  localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;

  typedef enum {FILE_GOOD, FILE_CUT, FILE_BAD_SIG, FILE_AFTER_END, FILE_NO_END, FILE_HUGE}
    file_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  pngcs_in_t data = '0;
  logic empty;
  logic pop = 1'b0;
  pngcs_out_t result;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  // stimulus and expectation stores
  pngcs_in_t file_bytes_q[$];
  logic [7:0] file_buf[$];
  pngcs_out_t filtered_due[$];
  int bytes_queued = 0;
  int bytes_sent_total = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  // handshake bookkeeping shared between monitor and driver
  bit byte_sent = 1'b0;
  bit result_taken = 1'b0;
  int send_gap = 0;
  int send_run = 0;
  int take_gap = 0;
  int take_run = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;

  // model of the filter state
  logic [2:0] mdl_phase;
  logic [32:0] mdl_count;
  logic [63:0] mdl_hold;
  logic mdl_drop;
  logic mdl_end;
  logic [2:0] mdl_err;
  logic [3:0] mdl_mask;

  png_color_chunk_stripper_unit u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data(data),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic clear_file_model();
    mdl_phase = PH_SIG;
    mdl_count = '0;
    mdl_hold = '0;
    mdl_drop = 1'b0;
    mdl_end = 1'b0;
    mdl_err = ST_OK;
  endtask

  function automatic logic chunk_stripped(input logic [31:0] ctype);
    case (ctype)
      TYPE_GAMA: return mdl_mask[MASK_GAMA];
      TYPE_CHRM: return mdl_mask[MASK_CHRM];
      TYPE_SRGB: return mdl_mask[MASK_SRGB];
      TYPE_ICCP: return mdl_mask[MASK_ICCP];
      default: return 1'b0;
    endcase
  endfunction

  // predict the filtered output caused by one file byte
  task automatic filter_byte(input pngcs_in_t item);
    pngcs_out_t res_buf[9];
    int n;
    int i;
    logic [2:0] st;
    n = 0;
    for (i = 0; i < 9; i++) res_buf[i] = '0;
    case (mdl_phase)
      PH_SIG: begin
        if (item.data_byte == PNG_MAGIC[63 - 8 * mdl_count[2:0] -: 8]) begin
          res_buf[n].out_byte = item.data_byte;
          res_buf[n].byte_valid = 1'b1;
          n++;
          mdl_count++;
          if (mdl_count >= 8) begin
            mdl_phase = PH_HDR;
            mdl_count = '0;
          end
        end else begin
          mdl_err = ST_BAD_SIG;
          mdl_phase = PH_ERR;
        end
      end
      PH_HDR: begin
        mdl_hold = {mdl_hold[55:0], item.data_byte};
        mdl_count++;
        // header complete: decide keep or strip, release the held bytes if kept
        if (mdl_count >= 8 && !item.last_byte) begin
          mdl_end = (mdl_hold[31:0] == TYPE_IEND);
          mdl_drop = chunk_stripped(mdl_hold[31:0]);
          if (!mdl_drop) begin
            for (i = 7; i >= 0; i--) begin
              res_buf[n].out_byte = mdl_hold[8 * i +: 8];
              res_buf[n].byte_valid = 1'b1;
              n++;
            end
          end
          mdl_phase = PH_BODY;
          mdl_count = {1'b0, mdl_hold[63:32]} + 33'(CRC_BYTES);
        end
      end
      PH_BODY: begin
        if (!mdl_drop) begin
          res_buf[n].out_byte = item.data_byte;
          res_buf[n].byte_valid = 1'b1;
          n++;
        end
        if (mdl_count > 0) mdl_count--;
        if (mdl_count == 0) begin
          mdl_phase = mdl_end ? PH_TAIL : PH_HDR;
          mdl_hold = '0;
          mdl_drop = 1'b0;
        end
      end
      PH_TAIL: begin
        mdl_err = ST_AFTER_END;
        mdl_phase = PH_ERR;
      end
      default: ;
    endcase

    // closing status on the final result of the file
    if (item.last_byte) begin
      if (mdl_err != ST_OK) st = mdl_err;
      else if (mdl_phase == PH_SIG) st = ST_BAD_SIG;
      else if (mdl_phase == PH_TAIL) st = ST_OK;
      else if (mdl_phase == PH_HDR && mdl_count == 0) st = ST_NO_END;
      else st = ST_TRUNC;
      if (n == 0) n = 1;
      res_buf[n - 1].done_res = 1'b1;
      res_buf[n - 1].status = st;
      clear_file_model();
    end
    if (n > 0) res_buf[n - 1].last_result = 1'b1;
    for (i = 0; i < n; i++) filtered_due.push_back(res_buf[i]);
  endtask

  task automatic check_result(input pngcs_out_t got);
    pngcs_out_t want;
    if (filtered_due.size() == 0) begin
      $error("result with nothing expected: out_byte %0h done_res %0b status %0d",
             got.out_byte, got.done_res, got.status);
      fail_count++;
    end else begin
      want = filtered_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        fail_count++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
        fail_count++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
        fail_count++;
      end
    end
  endtask

  // wait cycles before the next transaction, with bursts of back-to-back ones
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      run = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // monitor: predict on accepted bytes, check accepted results, watchdog
  always @(posedge clk) begin
    byte_sent = push && !full && !rst;
    result_taken = pop && !empty && !rst;
    if (byte_sent) begin
      filter_byte(data);
      bytes_sent_total++;
    end
    if (result_taken) check_result(result);
    if (rst || byte_sent || result_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("png_color_chunk_stripper_unit_test NOT OK");
        $finish;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && !byte_sent) begin
      // transaction still waiting for acceptance
    end else if (send_gap > 0) begin
      send_gap--;
      push <= 1'b0;
    end else if (file_bytes_q.size() > 0) begin
      data <= file_bytes_q.pop_front();
      push <= 1'b1;
      send_gap = draw_gap(send_run);
    end else begin
      push <= 1'b0;
    end
  end

  // result receiver, with a long hold-off when the test sequence requests one
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (result_taken) take_gap = draw_gap(take_run);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // move the file under construction into the stimulus queue
  task automatic flush_file();
    pngcs_in_t item;
    int i;
    for (i = 0; i < file_buf.size(); i++) begin
      item.data_byte = file_buf[i];
      item.last_byte = (i == file_buf.size() - 1);
      file_bytes_q.push_back(item);
    end
    bytes_queued += file_buf.size();
    file_buf.delete();
  endtask

  task automatic put_u32(input logic [31:0] v);
    int i;
    for (i = 3; i >= 0; i--) file_buf.push_back(v[8 * i +: 8]);
  endtask

  task automatic put_sig();
    int i;
    for (i = 7; i >= 0; i--) file_buf.push_back(PNG_MAGIC[8 * i +: 8]);
  endtask

  task automatic put_chunk(input logic [31:0] ctype, input int len);
    put_u32(32'(len));
    put_u32(ctype);
    repeat (len + CRC_BYTES) file_buf.push_back(8'($urandom));
  endtask

  function automatic logic [31:0] pick_type();
    case ($urandom_range(0, 9))
      0: return TYPE_GAMA;
      1: return TYPE_CHRM;
      2: return TYPE_SRGB;
      3: return TYPE_ICCP;
      4: return $urandom;
      5: return TYPE_GAMA ^ (32'h1 << $urandom_range(0, 31));
      9: return TYPE_IEND;
      default: return TYPE_IHDR;
    endcase
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 5) == 0) return $urandom_range(7, 20);
    return $urandom_range(0, 6);
  endfunction

  task automatic gen_file(input file_kind_t kind);
    int nchunks;
    int cut;
    int k;
    put_sig();
    if (kind == FILE_BAD_SIG) begin
      k = $urandom_range(0, 7);
      file_buf[k] = file_buf[k] ^ 8'($urandom_range(1, 255));
    end
    nchunks = $urandom_range(0, 1);
    for (k = 0; k < nchunks; k++) put_chunk(pick_type(), pick_len());
    if (kind == FILE_HUGE) begin
      // long chunk cut short, exercises the upper length bits
      put_u32($urandom_range(0, 1) ? 32'hFFFFFFFF : 32'($urandom));
      put_u32(pick_type());
      repeat ($urandom_range(0, 5)) file_buf.push_back(8'($urandom));
    end else if (kind != FILE_NO_END) begin
      put_chunk(TYPE_IEND, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    end
    if (kind == FILE_AFTER_END) repeat ($urandom_range(1, 4)) file_buf.push_back(8'($urandom));
    if (kind == FILE_CUT) begin
      cut = $urandom_range(1, file_buf.size() - 1);
      while (file_buf.size() > cut) void'(file_buf.pop_back());
    end
    flush_file();
  endtask

  task automatic random_files(input int nbytes);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < nbytes) begin
      case ($urandom_range(0, 9))
        5: gen_file(FILE_CUT);
        6: gen_file(FILE_BAD_SIG);
        7: gen_file(FILE_AFTER_END);
        8: gen_file(FILE_NO_END);
        9: gen_file(FILE_HUGE);
        default: gen_file(FILE_GOOD);
      endcase
    end
  endtask

  // short files for the closing cases
  task automatic directed_files();
    file_buf.push_back(8'hFF);
    flush_file();
    file_buf.push_back(8'h89);
    file_buf.push_back(8'h50);
    file_buf.push_back(8'h4E);
    flush_file();
    put_sig();
    flush_file();
    // file ending on the last header byte: held header never released
    put_sig();
    put_u32(32'h0);
    put_u32(TYPE_IHDR);
    flush_file();
  endtask

  task automatic wait_idle();
    while (bytes_sent_total != bytes_queued || filtered_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mask writes happen only with the block drained
  task automatic write_mask(input logic [3:0] m);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    mdl_mask = m;
  endtask

  // test sequence
  initial begin
    mdl_mask = DROP_MASK_RESET;
    clear_file_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_files();
    random_files(BYTES_PER_PHASE);

    write_mask(4'h0);
    random_files(BYTES_PER_PHASE);

    write_mask(4'h5);
    random_files(BYTES_PER_PHASE);

    // receiver holds off while the sender keeps going
    write_mask(4'hF);
    hold_reqs++;
    random_files(BYTES_PER_PHASE);

    write_mask(4'($urandom_range(0, 15)));
    random_files(BYTES_PER_PHASE);

    write_mask(4'hA);
    random_files(BYTES_PER_PHASE);

    wait_idle();
    if (fail_count == 0) begin
      $display("png_color_chunk_stripper_unit_test OK");
    end else begin
      $display("png_color_chunk_stripper_unit_test NOT OK");
    end
    $finish;
  end

endmodule
